@@ rtl/lru_key_value_cache_top_defines.svh @@
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LKVC_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LKVC_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lkvc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  localparam int LKVC_MAX_ENTRIES = 16;
  localparam int LKVC_KEY_W       = 32;
  localparam int LKVC_VAL_W       = 32;
  localparam int LKVC_CAP_W       = 5;

  localparam logic [LKVC_CAP_W-1:0] LKVC_CAP_RESET = LKVC_CAP_W'(16);
  localparam logic [LKVC_VAL_W-1:0] LKVC_MISS_VAL  = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } lkvc_op_t;

  // recency update request for lkvc_rank
  typedef struct packed {
    logic en;
    logic set_valid;
    logic limit_all;
  } lkvc_upd_t;

endpackage

`default_nettype wire

@@ rtl/lkvc_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lkvc_store
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = LKVC_MAX_ENTRIES,
  parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic                  clk,
  input  wire logic [AW-1:0]         key_raddr,
  output logic      [LKVC_KEY_W-1:0] key_q,
  input  wire logic [AW-1:0]         data_raddr,
  output logic      [LKVC_VAL_W-1:0] data_q,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [LKVC_KEY_W-1:0] wkey,
  input  wire logic [LKVC_VAL_W-1:0] wdata
);

  logic [LKVC_KEY_W-1:0] key_mem  [MAX_ENTRIES];
  logic [LKVC_VAL_W-1:0] data_mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]  <= wkey;
      data_mem[waddr] <= wdata;
    end
    key_q  <= key_mem[key_raddr];
    data_q <= data_mem[data_raddr];
  end

endmodule

`default_nettype wire

@@ rtl/lkvc_rank.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lkvc_rank
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = LKVC_MAX_ENTRIES,
  parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int FW          = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [AW-1:0]   rd_idx,
  output logic                 valid_q,
  output logic      [AW-1:0]   age_q,
  output logic      [FW-1:0]   fill,
  input  wire lkvc_upd_t       upd,
  input  wire logic [AW-1:0]   tgt,
  input  wire logic [AW-1:0]   limit
);

  logic [MAX_ENTRIES-1:0] valid_r;
  logic [AW-1:0]          age_r [MAX_ENTRIES];
  logic [FW-1:0]          fill_r;

  // age 0 = newest (tgt); other valid ones below limit (or all) age +1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (upd.en) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (AW'(i) == tgt) begin
          age_r[i] <= '0;
        end else if (valid_r[i] && (upd.limit_all || age_r[i] < limit)) begin
          age_r[i] <= age_r[i] + AW'(1);
        end
      end
      if (upd.set_valid) begin
        valid_r[tgt] <= 1'b1;
        fill_r       <= fill_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    valid_q <= valid_r[rd_idx];
    age_q   <= age_r[rd_idx];
  end

  assign fill = fill_r;

endmodule

`default_nettype wire

@@ rtl/lru_key_value_cache_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel | Ports          | Contents (lowest bit first)
// --------+----------------+---------------------------------------------
// request | in_t*          | tdata: key[31:0], value[63:32]; tuser: opcode
// result  | out_t*         | tdata: read_value[31:0]; tuser: hit, evicted
// config  | cfg_wr_*       | capacity[4:0]
//
// Each request runs a scan of one entry a cycle through the single key
// comparator, then decide, update, and hand-off to the output register.
// in_tready is high only while the sequencer is idle; a waiting result does
// not block the next request until its own hand-off.
// Synchronous active-low reset clears valid bits, ranks, occupancy and sets
// capacity to 16; key and value storage is not cleared.

`include "lru_key_value_cache_top_defines.svh"

module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = LKVC_MAX_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [63:0]           in_tdata,   // key[31:0], value[63:32]
  input  wire logic                  in_tuser,   // opcode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [31:0]           out_tdata,  // read_value[31:0]
  output logic      [1:0]            out_tuser,  // hit[0], evicted[1]
  input  wire logic                  cfg_wr_en,
  input  wire logic [LKVC_CAP_W-1:0] cfg_wr_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (FW > LKVC_CAP_W) ? FW : LKVC_CAP_W;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_RESOLVE = 5'b00100,
    ST_UPDATE  = 5'b01000,
    ST_FIN     = 5'b10000
  } state_t;

  // control
  state_t                 st_r, st_nxt;
  logic [FW-1:0]          cnt_r, cnt_nxt;
  logic                   pend_r, pend_nxt;
  logic                   match_found_r, match_found_nxt;
  logic                   slot_found_r, slot_found_nxt;
  logic                   lru_found_r, lru_found_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic [LKVC_CAP_W-1:0]  cap_r, cap_nxt;
  lkvc_upd_t              upd_r, upd_nxt;
  logic                   wr_r, wr_nxt;

  // payload
  lkvc_op_t               op_r, op_nxt;
  logic [LKVC_KEY_W-1:0]  key_r, key_nxt;
  logic [LKVC_VAL_W-1:0]  val_r, val_nxt;
  logic [AW-1:0]          pend_idx_r, pend_idx_nxt;
  logic [AW-1:0]          match_idx_r, match_idx_nxt;
  logic [AW-1:0]          match_age_r, match_age_nxt;
  logic [AW-1:0]          slot_idx_r, slot_idx_nxt;
  logic [AW-1:0]          lru_idx_r, lru_idx_nxt;
  logic [AW-1:0]          tgt_r, tgt_nxt;
  logic [AW-1:0]          limit_r, limit_nxt;
  logic                   res_hit_r, res_hit_nxt;
  logic                   res_ev_r, res_ev_nxt;
  logic [LKVC_VAL_W-1:0]  res_rd_r, res_rd_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic                   out_ev_r, out_ev_nxt;
  logic [LKVC_VAL_W-1:0]  out_rd_r, out_rd_nxt;

  logic [LKVC_KEY_W-1:0]  key_q;
  logic [LKVC_VAL_W-1:0]  data_q;
  logic                   valid_q;
  logic [AW-1:0]          age_q;
  logic [FW-1:0]          fill;
  logic                   key_eq;
  logic                   full;
  logic                   scan_done;
  logic [FW-1:0]          fill_m1;

  lkvc_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW)
  ) u_store (
    .clk        (clk),
    .key_raddr  (cnt_r[AW-1:0]),
    .key_q      (key_q),
    .data_raddr (match_idx_r),
    .data_q     (data_q),
    .we         (wr_r),
    .waddr      (tgt_r),
    .wkey       (key_r),
    .wdata      (val_r)
  );

  lkvc_rank #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW),
    .FW          (FW)
  ) u_rank (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (cnt_r[AW-1:0]),
    .valid_q (valid_q),
    .age_q   (age_q),
    .fill    (fill),
    .upd     (upd_r),
    .tgt     (tgt_r),
    .limit   (limit_r)
  );

  // the shared comparator
  assign key_eq    = (key_q == key_r);
  assign scan_done = (cnt_r == FW'(MAX_ENTRIES));
  assign fill_m1   = fill - FW'(1);

  // capacity 0 acts as 1, above MAX_ENTRIES it saturates
  always_comb begin
    if (cap_r == '0) begin
      full = (fill != '0);
    end else begin
      full = (CW'(fill) >= CW'(cap_r)) || (fill == FW'(MAX_ENTRIES));
    end
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_rd_r;
  assign out_tuser  = {out_ev_r, out_hit_r};

  always_comb begin
    st_nxt          = st_r;
    cnt_nxt         = cnt_r;
    pend_nxt        = 1'b0;
    match_found_nxt = match_found_r;
    slot_found_nxt  = slot_found_r;
    lru_found_nxt   = lru_found_r;
    out_vld_nxt     = out_vld_r && !out_tready;
    cap_nxt         = cfg_wr_en ? cfg_wr_data : cap_r;
    upd_nxt         = '0;
    wr_nxt          = 1'b0;
    op_nxt          = op_r;
    key_nxt         = key_r;
    val_nxt         = val_r;
    pend_idx_nxt    = cnt_r[AW-1:0];
    match_idx_nxt   = match_idx_r;
    match_age_nxt   = match_age_r;
    slot_idx_nxt    = slot_idx_r;
    lru_idx_nxt     = lru_idx_r;
    tgt_nxt         = tgt_r;
    limit_nxt       = limit_r;
    res_hit_nxt     = res_hit_r;
    res_ev_nxt      = res_ev_r;
    res_rd_nxt      = res_rd_r;
    out_hit_nxt     = out_hit_r;
    out_ev_nxt      = out_ev_r;
    out_rd_nxt      = out_rd_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt          = lkvc_op_t'(in_tuser);
          key_nxt         = in_tdata[31:0];
          val_nxt         = in_tdata[63:32];
          cnt_nxt         = '0;
          match_found_nxt = 1'b0;
          slot_found_nxt  = 1'b0;
          lru_found_nxt   = 1'b0;
          st_nxt          = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // read issued at cnt_r, compared in the next cycle at pend_idx_r
        if (!scan_done) begin
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + FW'(1);
        end else begin
          st_nxt = ST_RESOLVE;
        end
        if (pend_r) begin
          if (valid_q) begin
            if (!match_found_r && key_eq) begin
              match_found_nxt = 1'b1;
              match_idx_nxt   = pend_idx_r;
              match_age_nxt   = age_q;
            end
            // ranks are distinct, so the oldest holds fill - 1
            if (FW'(age_q) == fill_m1) begin
              lru_found_nxt = 1'b1;
              lru_idx_nxt   = pend_idx_r;
            end
          end else if (!slot_found_r) begin
            slot_found_nxt = 1'b1;
            slot_idx_nxt   = pend_idx_r;
          end
        end
      end

      ST_RESOLVE: begin
        res_hit_nxt = match_found_r;
        res_ev_nxt  = 1'b0;
        res_rd_nxt  = '0;
        st_nxt      = ST_UPDATE;
        if (match_found_r) begin
          tgt_nxt    = match_idx_r;
          limit_nxt  = match_age_r;
          upd_nxt.en = 1'b1;
          wr_nxt     = (op_r == OP_PUT);
        end else if (op_r == OP_GET) begin
          res_rd_nxt = LKVC_MISS_VAL;
        end else if (full || !slot_found_r) begin
          tgt_nxt    = lru_found_r ? lru_idx_r : '0;
          limit_nxt  = fill_m1[AW-1:0];
          upd_nxt.en = 1'b1;
          wr_nxt     = 1'b1;
          res_ev_nxt = 1'b1;
        end else begin
          tgt_nxt           = slot_idx_r;
          upd_nxt.en        = 1'b1;
          upd_nxt.set_valid = 1'b1;
          upd_nxt.limit_all = 1'b1;
          wr_nxt            = 1'b1;
        end
      end

      ST_UPDATE: begin
        if (res_hit_r && (op_r == OP_GET)) begin
          res_rd_nxt = data_q;
        end
        st_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_hit_nxt = res_hit_r;
          out_ev_nxt  = res_ev_r;
          out_rd_nxt  = res_rd_r;
          st_nxt      = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      cnt_r         <= '0;
      pend_r        <= 1'b0;
      match_found_r <= 1'b0;
      slot_found_r  <= 1'b0;
      lru_found_r   <= 1'b0;
      out_vld_r     <= 1'b0;
      cap_r         <= LKVC_CAP_RESET;
      upd_r         <= '0;
      wr_r          <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      cnt_r         <= cnt_nxt;
      pend_r        <= pend_nxt;
      match_found_r <= match_found_nxt;
      slot_found_r  <= slot_found_nxt;
      lru_found_r   <= lru_found_nxt;
      out_vld_r     <= out_vld_nxt;
      cap_r         <= cap_nxt;
      upd_r         <= upd_nxt;
      wr_r          <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    pend_idx_r  <= pend_idx_nxt;
    match_idx_r <= match_idx_nxt;
    match_age_r <= match_age_nxt;
    slot_idx_r  <= slot_idx_nxt;
    lru_idx_r   <= lru_idx_nxt;
    tgt_r       <= tgt_nxt;
    limit_r     <= limit_nxt;
    res_hit_r   <= res_hit_nxt;
    res_ev_r    <= res_ev_nxt;
    res_rd_r    <= res_rd_nxt;
    out_hit_r   <= out_hit_nxt;
    out_ev_r    <= out_ev_nxt;
    out_rd_r    <= out_rd_nxt;
  end

  `LKVC_AST_NXT(a_accept_starts_scan, in_tvalid && in_tready,
                (st_r == ST_SCAN) && (cnt_r == '0), "accepted item did not start a scan")
  `LKVC_AST_IMP(a_resolve_after_full_scan, st_r == ST_RESOLVE,
                cnt_r == FW'(MAX_ENTRIES), "decision taken before scan finished")
  `LKVC_AST_IMP(a_no_hit_and_evict, out_vld_r, !(out_hit_r && out_ev_r),
                "result flags both hit and eviction")
  `LKVC_AST_NXT(a_update_one_cycle, upd_r.en, !upd_r.en && !wr_r,
                "rank update or write held beyond one cycle")

endmodule

`default_nettype wire
